// ===== rtl/core/fla_pkg.sv =====
// ============================================================================
// fla_pkg
// Shared types and constants of the free-list slot allocator.
// ============================================================================
package fla_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int SIZE_W      = IDX_W + 1;

    localparam logic [SIZE_W-1:0] LIST_NIL   = SIZE_W'(MAX_ENTRIES);
    localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(MAX_ENTRIES);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_ENTRIES);

    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_EMPTY       = 2'd1,
        ST_BAD_RELEASE = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic commit;
    } ctl_t;

endpackage

// ===== rtl/core/fla_cmd_if.sv =====
// ============================================================================
// fla_cmd_if
// Command channel: allocate or release beat with slot index.
// ============================================================================
interface fla_cmd_if;
    import fla_pkg::*;

    logic                 valid;
    logic                 ready;
    command_t             command;
    logic [IDX_W-1:0]     entry_index;

    modport source (output valid, output command, output entry_index, input ready);
    modport sink   (input valid, input command, input entry_index, output ready);
endinterface

// ===== rtl/core/fla_rsp_if.sv =====
// ============================================================================
// fla_rsp_if
// Response channel: status and granted slot index.
// ============================================================================
interface fla_rsp_if;
    import fla_pkg::*;

    logic                 valid;
    logic                 ready;
    status_t              status;
    logic [IDX_W-1:0]     granted_index;

    modport source (output valid, output status, output granted_index, input ready);
    modport sink   (input valid, input status, input granted_index, output ready);
endinterface

// ===== rtl/core/free_list_slot_allocator.sv =====
// ============================================================================
// free_list_slot_allocator
// LIFO free-list allocator over up to 256 slots; allocate pops the head,
// release pushes a busy slot back, pool_size write rebuilds the list.
//
//   Channel  Dir  Payload                        Handshake
//   cmd      in   command, entry_index           valid/ready
//   rsp      out  status, granted_index          valid/ready
//   cfg      in   cfg_wr_data (pool_size)        cfg_wr_en
//
// Each command runs as accept, then execute; the link memory read
// launched at accept is ready at execute.
// Reset and pool_size writes rebuild the free list at once; no clearing pass.
// A result waiting in the output register holds the execute step; the next
// command beat is taken the cycle after the result is loaded.
// ============================================================================
module free_list_slot_allocator
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [fla_pkg::SIZE_W-1:0]  cfg_wr_data,
    fla_cmd_if.sink                     cmd,
    fla_rsp_if.source                   rsp
);
    import fla_pkg::*;

    ctl_t ctl;

    fla_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctl       (ctl)
    );

    fla_dp u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_command        (cmd.command),
        .in_entry_index    (cmd.entry_index),
        .out_status        (rsp.status),
        .out_granted_index (rsp.granted_index)
    );

endmodule

// ===== rtl/core/fla_ctrl.sv =====
// ============================================================================
// fla_ctrl
// Sequencer: accepts a command beat, runs the execute step, holds the result
// valid until the response beat is taken.
// ============================================================================
module fla_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output fla_pkg::ctl_t ctl
);
    import fla_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_comb
    begin
        ctl.load       = (state_reg == S_IDLE) && cmd_valid;
        ctl.commit     = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (ctl.commit)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

`ifndef SYNTHESIS
    a_load_to_exec : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> (state_reg == S_EXEC))
        else $error("load did not advance to execute");

    a_rsp_from_commit : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(ctl.commit))
        else $error("response raised without a commit");
`endif

endmodule

// ===== rtl/core/fla_dp.sv =====
// ============================================================================
// fla_dp
// Datapath: pool size, list head, fresh mark, busy bits, link memory with
// registered read, and the result register.
// ============================================================================
module fla_dp
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  fla_pkg::ctl_t                ctl,
    input  logic                         cfg_wr_en,
    input  logic [fla_pkg::SIZE_W-1:0]   cfg_wr_data,
    input  fla_pkg::command_t            in_command,
    input  logic [fla_pkg::IDX_W-1:0]    in_entry_index,
    output fla_pkg::status_t             out_status,
    output logic [fla_pkg::IDX_W-1:0]    out_granted_index
);
    import fla_pkg::*;

    logic [SIZE_W-1:0]      pool_size_reg;
    logic [SIZE_W-1:0]      pool_size_next;
    logic [SIZE_W-1:0]      list_head_reg;
    logic [SIZE_W-1:0]      list_head_next;
    logic [SIZE_W-1:0]      fresh_mark_reg;
    logic [SIZE_W-1:0]      fresh_mark_next;
    logic [MAX_ENTRIES-1:0] busy_reg;
    logic [MAX_ENTRIES-1:0] busy_next;

    command_t               command_reg;
    logic [IDX_W-1:0]       index_reg;
    logic [SIZE_W-1:0]      link_rd_reg;
    status_t                status_reg;
    status_t                status_next;
    logic [IDX_W-1:0]       granted_reg;
    logic [IDX_W-1:0]       granted_next;

    logic [SIZE_W-1:0]      link_mem [MAX_ENTRIES];

    logic [SIZE_W-1:0]      eff_size;
    logic                   head_ok;
    logic                   fresh_ok;
    logic                   release_ok;
    logic                   link_wr;

    always_comb
    begin
        eff_size   = (pool_size_reg > SIZE_LIMIT) ? SIZE_LIMIT : pool_size_reg;
        head_ok    = list_head_reg < eff_size;
        fresh_ok   = fresh_mark_reg < eff_size;
        release_ok = ({1'b0, index_reg} < eff_size) && busy_reg[index_reg];

        pool_size_next  = pool_size_reg;
        list_head_next  = list_head_reg;
        fresh_mark_next = fresh_mark_reg;
        busy_next       = busy_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        link_wr         = 1'b0;

        if (cfg_wr_en)
        begin
            pool_size_next  = cfg_wr_data;
            list_head_next  = LIST_NIL;
            fresh_mark_next = '0;
            busy_next       = '0;
        end
        else if (ctl.commit)
        begin
            status_next  = ST_OK;
            granted_next = '0;
            if (command_reg == CMD_ALLOC)
            begin
                if (head_ok)
                begin
                    granted_next                       = list_head_reg[IDX_W-1:0];
                    list_head_next                     = link_rd_reg;
                    busy_next[list_head_reg[IDX_W-1:0]] = 1'b1;
                end
                else if (fresh_ok)
                begin
                    granted_next                         = fresh_mark_reg[IDX_W-1:0];
                    fresh_mark_next                      = fresh_mark_reg + 1'b1;
                    busy_next[fresh_mark_reg[IDX_W-1:0]] = 1'b1;
                end
                else
                begin
                    status_next = ST_EMPTY;
                end
            end
            else
            begin
                if (release_ok)
                begin
                    busy_next[index_reg] = 1'b0;
                    list_head_next       = {1'b0, index_reg};
                    link_wr              = 1'b1;
                end
                else
                begin
                    status_next = ST_BAD_RELEASE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg  <= SIZE_RESET;
            list_head_reg  <= LIST_NIL;
            fresh_mark_reg <= '0;
            busy_reg       <= '0;
        end
        else
        begin
            pool_size_reg  <= pool_size_next;
            list_head_reg  <= list_head_next;
            fresh_mark_reg <= fresh_mark_next;
            busy_reg       <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            command_reg <= in_command;
            index_reg   <= in_entry_index;
        end
        status_reg  <= status_next;
        granted_reg <= granted_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            link_rd_reg <= link_mem[list_head_reg[IDX_W-1:0]];
        end
        if (link_wr)
        begin
            link_mem[index_reg] <= list_head_reg;
        end
    end

    assign out_status        = status_reg;
    assign out_granted_index = granted_reg;

`ifndef SYNTHESIS
    a_head_range : assert property (@(posedge clk) disable iff (!rst_n)
        list_head_reg[IDX_W] |-> (list_head_reg[IDX_W-1:0] == '0))
        else $error("list head beyond empty marker");

    a_grant_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.commit && !cfg_wr_en && (command_reg == CMD_ALLOC) && (head_ok || fresh_ok))
        |=> busy_reg[granted_reg])
        else $error("granted slot not marked busy");
`endif

endmodule

// ===== tb/sv/tb_free_list_slot_allocator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_free_list_slot_allocator
// Self-checking bench for the free-list slot allocator. A queue-fed driver
// sends allocate/release beats and pool_size writes. A shadow pool predicts
// status and granted slot for each accepted beat, and the monitor compares
// each response beat against the oldest prediction. Idle and stall rates
// change across the run.
// ============================================================================
module tb_free_list_slot_allocator;
    import fla_pkg::*;

    localparam int INDEX_SPAN = 1 << IDX_W;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [MAX_ENTRIES-1:0][SIZE_W-1:0] link;
        logic [MAX_ENTRIES-1:0]             busy;
        logic [SIZE_W-1:0]                  size;
        logic [SIZE_W-1:0]                  head;
        logic [SIZE_W-1:0]                  fresh;
        status_t                            st;
        logic [IDX_W-1:0]                   grant;
    } pool_t;

    typedef struct packed {
        logic             is_cfg;
        command_t         command;
        logic [IDX_W-1:0] index;
        logic [SIZE_W-1:0] size;
    } pending_t;

    typedef struct packed {
        status_t          st;
        logic [IDX_W-1:0] grant;
    } reply_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [SIZE_W-1:0]  cfg_wr_data = '0;
    logic               cmd_valid = 1'b0;
    command_t           cmd_command = CMD_ALLOC;
    logic [IDX_W-1:0]   cmd_index = '0;
    logic               rsp_ready = 1'b0;

    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 mismatches = 0;
    int                 quiet_cycles = 0;

    pending_t           pending_cmds[$];
    reply_t             owed_replies[$];
    pool_t              slot_pool;
    pool_t              plan_pool;

    fla_cmd_if cmd_if();
    fla_rsp_if rsp_if();

    assign cmd_if.valid       = cmd_valid;
    assign cmd_if.command     = cmd_command;
    assign cmd_if.entry_index = cmd_index;
    assign rsp_if.ready       = rsp_ready;

    free_list_slot_allocator dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd_if),
        .rsp         (rsp_if)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int pool_span(input logic [SIZE_W-1:0] sz);
        int n;
        n = int'(sz);
        if (n > MAX_ENTRIES)
            n = MAX_ENTRIES;
        if (n > INDEX_SPAN)
            n = INDEX_SPAN;
        return n;
    endfunction

    function automatic pool_t pool_rebuild(input logic [SIZE_W-1:0] sz);
        pool_t p;
        p = '0;
        p.size = sz;
        p.head = LIST_NIL;
        return p;
    endfunction

    function automatic pool_t pool_apply(input pool_t p, input command_t c,
                                         input logic [IDX_W-1:0] idx);
        pool_t q;
        int    n;
        q = p;
        n = pool_span(p.size);
        q.st = ST_OK;
        q.grant = '0;
        if (c == CMD_ALLOC)
        begin
            if (int'(p.head) < n)
            begin
                q.grant = p.head[IDX_W-1:0];
                q.head = p.link[p.head[IDX_W-1:0]];
                q.busy[p.head[IDX_W-1:0]] = 1'b1;
            end
            else if (int'(p.fresh) < n)
            begin
                q.grant = p.fresh[IDX_W-1:0];
                q.fresh = p.fresh + 1'b1;
                q.busy[p.fresh[IDX_W-1:0]] = 1'b1;
            end
            else
                q.st = ST_EMPTY;
        end
        else if (int'(idx) >= n || !p.busy[idx])
            q.st = ST_BAD_RELEASE;
        else
        begin
            q.busy[idx] = 1'b0;
            q.link[idx] = p.head;
            q.head = {1'b0, idx};
        end
        return q;
    endfunction

    function automatic logic [IDX_W-1:0] pick_busy_slot(input pool_t p);
        int start;
        start = $urandom_range(INDEX_SPAN - 1, 0);
        for (int k = 0; k < INDEX_SPAN; k++)
        begin
            if (p.busy[(start + k) % INDEX_SPAN])
                return IDX_W'((start + k) % INDEX_SPAN);
        end
        return IDX_W'(start);
    endfunction

    task automatic queue_cmd(input command_t c, input logic [IDX_W-1:0] idx);
        pending_t item;
        item = '0;
        item.command = c;
        item.index = idx;
        pending_cmds.push_back(item);
        plan_pool = pool_apply(plan_pool, c, idx);
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || cmd_valid || cfg_wr_en
               || owed_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        while (pending_cmds.size() != 0 || cmd_valid || cfg_wr_en
               || owed_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic queue_size_write(input logic [SIZE_W-1:0] sz);
        pending_t item;
        wait_idle();
        item = '0;
        item.is_cfg = 1'b1;
        item.size = sz;
        pending_cmds.push_back(item);
        plan_pool = pool_rebuild(sz);
    endtask

    task automatic queue_mix(input int count, input int alloc_pct, input int noise_pct);
        int roll;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99, 0);
            if (roll < alloc_pct)
                queue_cmd(CMD_ALLOC, IDX_W'($urandom_range(INDEX_SPAN - 1, 0)));
            else if (roll < 100 - noise_pct)
                queue_cmd(CMD_RELEASE, pick_busy_slot(plan_pool));
            else
                queue_cmd(CMD_RELEASE, IDX_W'($urandom_range(INDEX_SPAN - 1, 0)));
        end
    endtask

    // driver: hold a beat until taken, then load the next pending one
    always @(posedge clk or negedge rst_n)
    begin : drive
        logic next_valid;
        logic next_wr;
        reply_t owed;
        if (!rst_n)
        begin
            slot_pool = pool_rebuild(SIZE_RESET);
            cmd_valid <= 1'b0;
            cfg_wr_en <= 1'b0;
        end
        else
        begin
            next_valid = cmd_valid;
            next_wr = 1'b0;
            if (cmd_valid && cmd_if.ready)
            begin
                slot_pool = pool_apply(slot_pool, cmd_command, cmd_index);
                owed.st = slot_pool.st;
                owed.grant = slot_pool.grant;
                owed_replies.push_back(owed);
                next_valid = 1'b0;
            end
            if (!next_valid && !cfg_wr_en && pending_cmds.size() != 0)
            begin
                if (pending_cmds[0].is_cfg)
                begin
                    next_wr = 1'b1;
                    cfg_wr_data <= pending_cmds[0].size;
                    slot_pool = pool_rebuild(pending_cmds[0].size);
                    void'(pending_cmds.pop_front());
                end
                else if ($urandom_range(99, 0) >= send_idle_pct)
                begin
                    next_valid = 1'b1;
                    cmd_command <= pending_cmds[0].command;
                    cmd_index <= pending_cmds[0].index;
                    void'(pending_cmds.pop_front());
                end
            end
            cmd_valid <= next_valid;
            cfg_wr_en <= next_wr;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch_responses
        reply_t owed;
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_ready && rsp_if.valid)
            begin
                if (owed_replies.size() == 0)
                begin
                    $display("%0t: unexpected response beat status=%0d granted_index=%0d",
                             $time, rsp_if.status, rsp_if.granted_index);
                    mismatches++;
                end
                else
                begin
                    owed = owed_replies.pop_front();
                    if (rsp_if.status !== owed.st)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, owed.st, rsp_if.status);
                        mismatches++;
                    end
                    if (rsp_if.granted_index !== owed.grant)
                    begin
                        $display("%0t: granted_index expected %0d actual %0d",
                                 $time, owed.grant, rsp_if.granted_index);
                        mismatches++;
                    end
                end
            end
            rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_if.ready) || (rsp_ready && rsp_if.valid) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int sz;
        plan_pool = pool_rebuild(SIZE_RESET);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset pool of 256: head reuse, double release, never-granted release
        queue_cmd(CMD_ALLOC, 8'hFF);
        queue_cmd(CMD_ALLOC, 8'h00);
        queue_cmd(CMD_ALLOC, 8'h00);
        queue_cmd(CMD_RELEASE, 8'd1);
        queue_cmd(CMD_RELEASE, 8'd1);
        queue_cmd(CMD_RELEASE, 8'd200);
        queue_cmd(CMD_ALLOC, 8'h00);
        queue_cmd(CMD_RELEASE, 8'd0);
        queue_cmd(CMD_RELEASE, 8'd2);
        queue_cmd(CMD_ALLOC, 8'h00);
        queue_cmd(CMD_ALLOC, 8'h00);
        queue_cmd(CMD_ALLOC, 8'h00);
        queue_cmd(CMD_RELEASE, 8'd255);
        queue_cmd(CMD_RELEASE, 8'd3);
        queue_cmd(CMD_ALLOC, 8'hFF);

        // empty pool
        queue_size_write(9'd0);
        queue_cmd(CMD_ALLOC, 8'h00);
        queue_cmd(CMD_RELEASE, 8'd0);
        queue_cmd(CMD_RELEASE, 8'd255);

        // single slot: exhaust, out of range, double release
        queue_size_write(9'd1);
        queue_cmd(CMD_ALLOC, 8'h00);
        queue_cmd(CMD_ALLOC, 8'h00);
        queue_cmd(CMD_RELEASE, 8'd1);
        queue_cmd(CMD_RELEASE, 8'd0);
        queue_cmd(CMD_RELEASE, 8'd0);
        queue_cmd(CMD_ALLOC, 8'h00);

        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 0)
                sz = 256;
            else if (ph == 1)
                sz = 511;
            else if (ph == 6)
                sz = 2;
            else
                sz = $urandom_range(20, 1);
            queue_size_write(SIZE_W'(sz));
            if (ph < 4)
            begin
                send_idle_pct <= 21;
                recv_stall_pct <= 85;
            end
            else if (ph < 8)
            begin
                send_idle_pct <= 85;
                recv_stall_pct <= 21;
            end
            else
            begin
                send_idle_pct <= 0;
                recv_stall_pct <= 0;
            end
            // oversized pool: run the fresh region past the cap
            if (ph == 1)
                queue_mix(262, 96, 1);
            else
                queue_mix(20, $urandom_range(65, 35), 10);
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
